FILE: design/ultx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ultx_pkg
// Shared types and constants of the priority LIFO transmit scheduler.
// ----------------------------------------------------------------------------
package ultx_pkg;

  localparam int PRIO_LEVELS = 4;
  localparam int LIFO_DEPTH  = 8;
  localparam int SEEN_DEPTH  = 32;
  localparam int TOTAL_CAP   = 32;

  localparam int PRIO_W     = $clog2(PRIO_LEVELS);
  localparam int IDX_W      = $clog2(LIFO_DEPTH);
  localparam int CNT_W      = $clog2(LIFO_DEPTH + 1);
  localparam int SEEN_IDX_W = $clog2(SEEN_DEPTH);
  localparam int SEEN_CNT_W = $clog2(SEEN_DEPTH + 1);
  localparam int TOT_W      = $clog2(TOTAL_CAP + 1);
  localparam int BUF_W      = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYTES_PER_TICK = 3'd0,
    CFG_EXPIRE_TICKS   = 3'd1,
    CFG_BACKLOG_FACTOR = 3'd2,
    CFG_IPV4_PRESENT   = 3'd3,
    CFG_IPV6_PRESENT   = 3'd4
  } ultx_cfg_e;

  typedef enum logic [3:0] {
    EV_SENT_DIRECT = 4'd0,
    EV_QUEUED      = 4'd1,
    EV_REFUSED     = 4'd2,
    EV_ZERO_PORT   = 4'd3,
    EV_UNNEEDED    = 4'd4,
    EV_NO_SOCKET   = 4'd5,
    EV_SENT_QUEUED = 4'd6,
    EV_EXPIRED     = 4'd7,
    EV_TICK_DONE   = 4'd8
  } ultx_event_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PKT,
    ST_TICK,
    ST_EXP,
    ST_RINIT,
    ST_SCAN,
    ST_SEEN,
    ST_REND,
    ST_DONE
  } ultx_state_e;

  typedef struct packed {
    logic        op;
    logic [1:0]  packet_prio;
    logic [31:0] dest_addr_key;
    logic [15:0] dest_port;
    logic        is_ipv6;
    logic [15:0] packet_length;
    logic        can_transmit;
    logic [15:0] packet_tag;
  } ultx_in_t;

  typedef struct packed {
    logic [3:0]       event_kind;
    logic [15:0]      result_tag;
    logic [1:0]       result_prio;
    logic [15:0]      result_length;
    logic [BUF_W-1:0] buffered_now;
    logic             wake_upper;
    logic             last_of_run;
  } ultx_out_t;

  typedef struct packed {
    logic load;
    logic pkt;
    logic tick_init;
    logic exp_step;
    logic round_init;
    logic scan_step;
    logic seen_step;
    logic round_next;
    logic done;
  } ultx_cmd_t;

  typedef struct packed {
    logic exp_more;
    logic exp_last_prio;
    logic scan_end;
    logic scan_seen;
    logic seen_exit;
    logic round_stop;
  } ultx_sts_t;

endpackage
`default_nettype wire

FILE: design/ultx_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ultx_ctrl
// Sequencer: packet handling, expiry sweep, send rounds and tick completion.
// ----------------------------------------------------------------------------
module ultx_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic                op_i,
  input  wire ultx_pkg::ultx_sts_t sts_i,
  output ultx_pkg::ultx_cmd_t      cmd_o,
  output logic                     busy_o
);

  ultx_pkg::ultx_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ultx_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ultx_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = op_i ? ultx_pkg::ST_TICK : ultx_pkg::ST_PKT;
        end
      end
      ultx_pkg::ST_PKT:   state_d = ultx_pkg::ST_IDLE;
      ultx_pkg::ST_TICK:  state_d = ultx_pkg::ST_EXP;
      ultx_pkg::ST_EXP: begin
        if (!sts_i.exp_more && sts_i.exp_last_prio) begin
          state_d = ultx_pkg::ST_RINIT;
        end
      end
      ultx_pkg::ST_RINIT: state_d = ultx_pkg::ST_SCAN;
      ultx_pkg::ST_SCAN: begin
        if (sts_i.scan_end) begin
          state_d = ultx_pkg::ST_REND;
        end else if (sts_i.scan_seen) begin
          state_d = ultx_pkg::ST_SEEN;
        end
      end
      ultx_pkg::ST_SEEN: begin
        if (sts_i.seen_exit) begin
          state_d = ultx_pkg::ST_SCAN;
        end
      end
      ultx_pkg::ST_REND: begin
        state_d = sts_i.round_stop ? ultx_pkg::ST_DONE : ultx_pkg::ST_RINIT;
      end
      ultx_pkg::ST_DONE:  state_d = ultx_pkg::ST_IDLE;
      default:            state_d = ultx_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = (state_q == ultx_pkg::ST_IDLE) && start_i;
    cmd_o.pkt        = (state_q == ultx_pkg::ST_PKT);
    cmd_o.tick_init  = (state_q == ultx_pkg::ST_TICK);
    cmd_o.exp_step   = (state_q == ultx_pkg::ST_EXP);
    cmd_o.round_init = (state_q == ultx_pkg::ST_RINIT);
    cmd_o.scan_step  = (state_q == ultx_pkg::ST_SCAN);
    cmd_o.seen_step  = (state_q == ultx_pkg::ST_SEEN);
    cmd_o.round_next = (state_q == ultx_pkg::ST_REND) && !sts_i.round_stop;
    cmd_o.done       = (state_q == ultx_pkg::ST_DONE);
    busy_o           = (state_q != ultx_pkg::ST_IDLE);
  end

endmodule
`default_nettype wire

FILE: design/ultx_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ultx_datapath
// Queues, budget, seen set, configuration and the registered result beat.
// ----------------------------------------------------------------------------
module ultx_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [ultx_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [ultx_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire ultx_pkg::ultx_in_t                  item_i,
  input  wire ultx_pkg::ultx_cmd_t                 cmd_i,
  output ultx_pkg::ultx_sts_t                      sts_o,
  output logic                                     res_valid_o,
  output ultx_pkg::ultx_out_t                      res_o
);

  typedef struct packed {
    logic [15:0] tag;
    logic [1:0]  prio;
    logic [31:0] key;
    logic [15:0] port;
    logic        v6;
    logic [15:0] len;
    logic        ok;
    logic [31:0] expire;
  } qent_t;

  localparam int P  = ultx_pkg::PRIO_LEVELS;
  localparam int D  = ultx_pkg::LIFO_DEPTH;
  localparam int BW = ultx_pkg::BUF_W;

  // configuration
  logic [19:0] bpt_q;
  logic [7:0]  exp_ticks_q;
  logic [3:0]  factor_q;
  logic        sock4_q, sock6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpt_q       <= 20'd65536;
      exp_ticks_q <= 8'd5;
      factor_q    <= 4'd3;
      sock4_q     <= 1'b1;
      sock6_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ultx_pkg::CFG_BYTES_PER_TICK: bpt_q       <= cfg_wdata_i;
        ultx_pkg::CFG_EXPIRE_TICKS:   exp_ticks_q <= cfg_wdata_i[7:0];
        ultx_pkg::CFG_BACKLOG_FACTOR: factor_q    <= cfg_wdata_i[3:0];
        ultx_pkg::CFG_IPV4_PRESENT:   sock4_q     <= cfg_wdata_i[0];
        ultx_pkg::CFG_IPV6_PRESENT:   sock6_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // state
  ultx_pkg::ultx_in_t in_q, in_d;
  qent_t ent_q [P][D];
  qent_t ent_d [P][D];
  logic [47:0] seen_q [ultx_pkg::SEEN_DEPTH];
  logic [47:0] seen_d [ultx_pkg::SEEN_DEPTH];

  logic [ultx_pkg::CNT_W-1:0]      cnt_q [P];
  logic [ultx_pkg::CNT_W-1:0]      cnt_d [P];
  logic [ultx_pkg::TOT_W-1:0]      tot_q, tot_d, round_q, round_d;
  logic [BW-1:0]                   buf_q, buf_d;
  logic [31:0]                     time_q, time_d;
  logic [19:0]                     budget_q, budget_d;
  logic                            exh_q, exh_d, thr_q, thr_d;
  logic [ultx_pkg::SEEN_CNT_W-1:0] seen_cnt_q, seen_cnt_d, k_q, k_d;
  logic [ultx_pkg::PRIO_W-1:0]     p_q, p_d;
  logic [ultx_pkg::CNT_W-1:0]      i_q, i_d;
  ultx_pkg::ultx_out_t             res_q, res_d;
  logic                            res_vld_q, res_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int x = 0; x < P; x++) cnt_q[x] <= '0;
      tot_q      <= '0;
      round_q    <= '0;
      buf_q      <= '0;
      time_q     <= '0;
      budget_q   <= '0;
      exh_q      <= 1'b0;
      thr_q      <= 1'b0;
      seen_cnt_q <= '0;
      k_q        <= '0;
      p_q        <= '0;
      i_q        <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      for (int x = 0; x < P; x++) cnt_q[x] <= cnt_d[x];
      tot_q      <= tot_d;
      round_q    <= round_d;
      buf_q      <= buf_d;
      time_q     <= time_d;
      budget_q   <= budget_d;
      exh_q      <= exh_d;
      thr_q      <= thr_d;
      seen_cnt_q <= seen_cnt_d;
      k_q        <= k_d;
      p_q        <= p_d;
      i_q        <= i_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    res_q <= res_d;
    ent_q <= ent_d;
    seen_q <= seen_d;
  end

  function automatic logic [4:0] attempt_f(input logic [15:0] port, input logic ok,
                                           input logic v6, input logic [15:0] len,
                                           input logic [19:0] budget,
                                           input logic s4, input logic s6);
    logic [4:0] r;
    r = {1'b0, ultx_pkg::EV_SENT_DIRECT};
    if (port == 16'd0) begin
      r = {1'b0, ultx_pkg::EV_ZERO_PORT};
    end else if (!ok) begin
      r = {1'b0, ultx_pkg::EV_UNNEEDED};
    end else if (!(v6 ? s6 : s4)) begin
      r = {1'b0, ultx_pkg::EV_NO_SOCKET};
    end else if ({4'd0, len} > budget) begin
      r = {1'b1, ultx_pkg::EV_SENT_DIRECT};
    end
    return r;
  endfunction

  function automatic ultx_pkg::ultx_out_t mk_res(input logic [3:0] kind,
                                                 input logic [15:0] tag,
                                                 input logic [1:0] prio,
                                                 input logic [15:0] len,
                                                 input logic [BW-1:0] bufd,
                                                 input logic wake, input logic last);
    ultx_pkg::ultx_out_t o;
    o.event_kind    = kind;
    o.result_tag    = tag;
    o.result_prio   = prio;
    o.result_length = len;
    o.buffered_now  = bufd;
    o.wake_upper    = wake;
    o.last_of_run   = last;
    return o;
  endfunction

  // current entry and derived conditions
  qent_t                       cur, new_ent;
  logic [47:0]                 cur_dest;
  logic                        has, expired, seen_more, seen_hit, refuse, do_att, wake;
  logic [31:0]                 tdiff;
  logic [4:0]                  att_pkt, att_cur;
  logic [ultx_pkg::PRIO_W-1:0] q_in;
  logic [19:0]                 bw;
  logic [23:0]                 limit;
  logic [BW-1:0]               buf_sub;
  logic [3:0]                  kind_cur;

  assign cur      = ent_q[p_q][i_q[ultx_pkg::IDX_W-1:0]];
  assign cur_dest = {cur.key, cur.port};
  assign has      = i_q < cnt_q[p_q];
  assign tdiff    = time_q - cur.expire;
  assign expired  = (tdiff != 32'd0) && !tdiff[31];
  assign seen_more = k_q < seen_cnt_q;
  assign seen_hit = seen_more && (seen_q[k_q[ultx_pkg::SEEN_IDX_W-1:0]] == cur_dest);
  assign att_pkt  = attempt_f(in_q.dest_port, in_q.can_transmit, in_q.is_ipv6,
                              in_q.packet_length, budget_q, sock4_q, sock6_q);
  assign att_cur  = attempt_f(cur.port, cur.ok, cur.v6, cur.len, budget_q, sock4_q, sock6_q);
  assign q_in     = (int'(in_q.packet_prio) < P) ? ultx_pkg::PRIO_W'(in_q.packet_prio)
                                                  : ultx_pkg::PRIO_W'(P - 1);
  assign bw       = (sock4_q || sock6_q) ? bpt_q : 20'd0;
  assign limit    = {20'd0, factor_q} * {4'd0, bw};
  assign refuse   = ((q_in != ultx_pkg::PRIO_W'(P - 1)) && ({3'd0, buf_q} >= limit)) ||
                    (cnt_q[q_in] >= ultx_pkg::CNT_W'(D)) ||
                    (tot_q >= ultx_pkg::TOT_W'(ultx_pkg::TOTAL_CAP));
  assign buf_sub  = (buf_q >= {5'd0, cur.len}) ? buf_q - {5'd0, cur.len} : '0;
  assign kind_cur = (att_cur[3:0] == ultx_pkg::EV_SENT_DIRECT) ? ultx_pkg::EV_SENT_QUEUED
                                                               : att_cur[3:0];
  assign wake     = !exh_q && thr_q;

  always_comb begin
    new_ent.tag    = in_q.packet_tag;
    new_ent.prio   = in_q.packet_prio;
    new_ent.key    = in_q.dest_addr_key;
    new_ent.port   = in_q.dest_port;
    new_ent.v6     = in_q.is_ipv6;
    new_ent.len    = in_q.packet_length;
    new_ent.ok     = in_q.can_transmit;
    new_ent.expire = time_q + {24'd0, exp_ticks_q};
  end

  always_comb begin
    in_d       = in_q;
    ent_d      = ent_q;
    seen_d     = seen_q;
    cnt_d      = cnt_q;
    tot_d      = tot_q;
    round_d    = round_q;
    buf_d      = buf_q;
    time_d     = time_q;
    budget_d   = budget_q;
    exh_d      = exh_q;
    thr_d      = thr_q;
    seen_cnt_d = seen_cnt_q;
    k_d        = k_q;
    p_d        = p_q;
    i_d        = i_q;
    res_d      = res_q;
    res_vld_d  = 1'b0;
    do_att     = 1'b0;

    if (cmd_i.load) begin
      in_d = item_i;
    end

    if (cmd_i.pkt) begin
      res_vld_d = 1'b1;
      if (!exh_q && !att_pkt[4]) begin
        if (att_pkt[3:0] == ultx_pkg::EV_SENT_DIRECT) begin
          budget_d = budget_q - {4'd0, in_q.packet_length};
        end
        res_d = mk_res(att_pkt[3:0], in_q.packet_tag, in_q.packet_prio,
                       in_q.packet_length, buf_q, 1'b0, 1'b1);
      end else begin
        exh_d = 1'b1;
        if (refuse) begin
          thr_d = 1'b1;
          res_d = mk_res(ultx_pkg::EV_REFUSED, in_q.packet_tag, in_q.packet_prio,
                         in_q.packet_length, buf_q, 1'b0, 1'b1);
        end else begin
          for (int j = 1; j < D; j++) ent_d[q_in][j] = ent_q[q_in][j-1];
          ent_d[q_in][0] = new_ent;
          cnt_d[q_in]    = cnt_q[q_in] + ultx_pkg::CNT_W'(1);
          tot_d          = tot_q + ultx_pkg::TOT_W'(1);
          buf_d          = buf_q + {5'd0, in_q.packet_length};
          res_d = mk_res(ultx_pkg::EV_QUEUED, in_q.packet_tag, in_q.packet_prio,
                         in_q.packet_length, buf_d, 1'b0, 1'b1);
        end
      end
    end

    if (cmd_i.tick_init) begin
      time_d   = time_q + 32'd1;
      budget_d = bpt_q;
      exh_d    = 1'b0;
      p_d      = '0;
      i_d      = '0;
      round_d  = '0;
    end

    if (cmd_i.exp_step) begin
      if (has) begin
        if (expired) begin
          for (int j = 0; j < D - 1; j++) begin
            if (j >= int'(i_q)) ent_d[p_q][j] = ent_q[p_q][j+1];
          end
          cnt_d[p_q] = cnt_q[p_q] - ultx_pkg::CNT_W'(1);
          tot_d      = tot_q - ultx_pkg::TOT_W'(1);
          buf_d      = buf_sub;
          res_vld_d  = 1'b1;
          res_d = mk_res(ultx_pkg::EV_EXPIRED, cur.tag, cur.prio, cur.len, buf_sub,
                         1'b0, 1'b0);
        end else begin
          i_d = i_q + ultx_pkg::CNT_W'(1);
        end
      end else if (p_q != ultx_pkg::PRIO_W'(P - 1)) begin
        p_d = p_q + ultx_pkg::PRIO_W'(1);
        i_d = '0;
      end
    end

    if (cmd_i.round_init) begin
      seen_cnt_d = '0;
      p_d        = ultx_pkg::PRIO_W'(P - 1);
      i_d        = '0;
    end

    if (cmd_i.scan_step && !exh_q) begin
      if (!has) begin
        if (p_q != '0) begin
          p_d = p_q - ultx_pkg::PRIO_W'(1);
          i_d = '0;
        end
      end else if (p_q == '0) begin
        k_d = '0;
      end else begin
        do_att = 1'b1;
      end
    end

    if (cmd_i.seen_step) begin
      if (seen_more) begin
        if (seen_hit) begin
          i_d = i_q + ultx_pkg::CNT_W'(1);
        end else begin
          k_d = k_q + ultx_pkg::SEEN_CNT_W'(1);
        end
      end else begin
        do_att = 1'b1;
      end
    end

    if (do_att) begin
      if (att_cur[4]) begin
        exh_d = 1'b1;
      end else begin
        if (att_cur[3:0] == ultx_pkg::EV_SENT_DIRECT) begin
          budget_d = budget_q - {4'd0, cur.len};
          if (p_q == '0 &&
              seen_cnt_q < ultx_pkg::SEEN_CNT_W'(ultx_pkg::SEEN_DEPTH)) begin
            seen_d[seen_cnt_q[ultx_pkg::SEEN_IDX_W-1:0]] = cur_dest;
            seen_cnt_d = seen_cnt_q + ultx_pkg::SEEN_CNT_W'(1);
          end
        end
        for (int j = 0; j < D - 1; j++) begin
          if (j >= int'(i_q)) ent_d[p_q][j] = ent_q[p_q][j+1];
        end
        cnt_d[p_q] = cnt_q[p_q] - ultx_pkg::CNT_W'(1);
        tot_d      = tot_q - ultx_pkg::TOT_W'(1);
        buf_d      = buf_sub;
        res_vld_d  = 1'b1;
        res_d = mk_res(kind_cur, cur.tag, cur.prio, cur.len, buf_sub, 1'b0, 1'b0);
      end
    end

    if (cmd_i.round_next) begin
      round_d = round_q + ultx_pkg::TOT_W'(1);
    end

    if (cmd_i.done) begin
      if (wake) thr_d = 1'b0;
      res_vld_d = 1'b1;
      res_d = mk_res(ultx_pkg::EV_TICK_DONE, 16'd0, 2'd0, 16'd0, buf_q, wake, 1'b1);
    end
  end

  always_comb begin
    sts_o.exp_more      = has;
    sts_o.exp_last_prio = (p_q == ultx_pkg::PRIO_W'(P - 1));
    sts_o.scan_end      = exh_q || (!has && p_q == '0);
    sts_o.scan_seen     = !exh_q && has && (p_q == '0);
    sts_o.seen_exit     = !seen_more || seen_hit;
    sts_o.round_stop    = exh_q || (buf_q == '0) ||
                          (round_q == ultx_pkg::TOT_W'(ultx_pkg::TOTAL_CAP));
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

FILE: design/udp_priority_lifo_tx_scheduler_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udp_priority_lifo_tx_scheduler_core
// Per-tick byte budget scheduler over priority LIFOs of datagram descriptors.
//
// Items enter on item_i when start_i is high and busy_o is low. Each result
// beat is on res_o for one cycle with res_valid_o high; the receiver takes
// it as it comes. last_of_run marks the final beat of an item.
// A packet item is registered in in_q, handled in ST_PKT and its single beat
// registered in res_q; busy_o is high for one cycle, so the next packet item
// can be accepted once ST_PKT is over. A tick runs ST_TICK, then an expiry
// sweep over every queued entry and priority, then send rounds: each scans
// the priorities and their entries, and for each data-priority entry it
// searches the seen set one entry a cycle, skipping the entry on a match;
// ST_DONE then gives the tick-done beat. Configuration (cfg_we_i, cfg_idx_i,
// cfg_wdata_i) is to be written while idle; the block does not enforce it.
// Reset empties all queues, clears time, budget and flags, and loads the
// register defaults; queue and seen-set contents are undefined until written.
// ----------------------------------------------------------------------------
module udp_priority_lifo_tx_scheduler_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire ultx_pkg::ultx_in_t              item_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [ultx_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ultx_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                                 res_valid_o,
  output ultx_pkg::ultx_out_t                  res_o
);

  ultx_pkg::ultx_cmd_t cmd;
  ultx_pkg::ultx_sts_t sts;

  ultx_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (item_i.op),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  ultx_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted item did not raise busy");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_of_run |=> !res_valid_o)
    else $error("beat directly after last of run");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.event_kind == ultx_pkg::EV_TICK_DONE |-> res_o.last_of_run)
    else $error("tick done not last");

  a_wake_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.wake_upper |-> res_o.event_kind == ultx_pkg::EV_TICK_DONE)
    else $error("wake on non tick beat");

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the priority LIFO transmit scheduler.
// Packet and tick items go in with random gaps (none in the last run); an in-bench scheduler model
// predicts each result beat, and the monitor checks every beat in order.
// The run steps through several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb;
  import ultx_pkg::*;

  localparam int WDOG_LIMIT = 200000;
  localparam int SETTLE     = 64;

  typedef struct {
    bit [15:0] tag;
    bit [1:0]  prio;
    bit [31:0] key;
    bit [15:0] port;
    bit        v6;
    bit [15:0] len;
    bit        ok;
    bit [31:0] expiry;
  } slot_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  ultx_in_t item_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic res_valid_o;
  ultx_out_t res_o;

  udp_priority_lifo_tx_scheduler_core uut (.*);

  always #1 clk_i = ~clk_i;

  // scheduler model
  bit [19:0] m_bpt;
  bit [7:0]  m_exp;
  bit [3:0]  m_fac;
  bit        m_v4, m_v6;
  slot_t     lifo [PRIO_LEVELS][LIFO_DEPTH];
  int        depth [PRIO_LEVELS];
  bit [20:0] queued_bytes;
  bit [31:0] now_tick;
  bit [19:0] budget;
  bit        spent, throttled;
  bit [47:0] served [SEEN_DEPTH];
  int        served_n;

  ultx_in_t  pkt_q [$];
  ultx_out_t due_q [$];
  int        errors = 0;
  bit        took = 1'b0;
  bit        calm = 1'b0;
  int        gap = 0;
  int        idle_cyc = 0;

  function automatic void note(ultx_event_e k, bit [15:0] tag, bit [1:0] pr,
                               bit [15:0] len, bit wake);
    ultx_out_t o;
    o.event_kind    = k;
    o.result_tag    = tag;
    o.result_prio   = pr;
    o.result_length = len;
    o.buffered_now  = queued_bytes;
    o.wake_upper    = wake;
    o.last_of_run   = 1'b0;
    due_q.push_back(o);
  endfunction

  // -1 when out of budget
  function automatic int try_send(bit [15:0] port, bit ok, bit v6, bit [15:0] len);
    if (port == 0) return EV_ZERO_PORT;
    if (!ok) return EV_UNNEEDED;
    if (!(v6 ? m_v6 : m_v4)) return EV_NO_SOCKET;
    if (len > budget) begin
      spent = 1'b1;
      return -1;
    end
    budget = budget - len;
    return EV_SENT_DIRECT;
  endfunction

  function automatic void drop_slot(int p, int i);
    for (int j = i; j + 1 < depth[p]; j++) lifo[p][j] = lifo[p][j+1];
    depth[p]--;
  endfunction

  function automatic void release_bytes(bit [15:0] len);
    queued_bytes = (queued_bytes >= len) ? queued_bytes - len : '0;
  endfunction

  function automatic void sched_predict(ultx_in_t it);
    slot_t s;
    int r, q, tot, i;
    int unsigned lim;
    bit hit, stop;
    bit [31:0] d;
    bit [47:0] dest;
    ultx_out_t o;
    if (it.op == 1'b0) begin
      s.tag = it.packet_tag; s.prio = it.packet_prio; s.key = it.dest_addr_key;
      s.port = it.dest_port; s.v6 = it.is_ipv6; s.len = it.packet_length;
      s.ok = it.can_transmit;
      q = it.packet_prio;
      r = -1;
      if (!spent) r = try_send(s.port, s.ok, s.v6, s.len);
      if (r >= 0) begin
        note(ultx_event_e'(r), s.tag, s.prio, s.len, 1'b0);
      end else begin
        lim = (m_v4 || m_v6) ? int'(m_fac) * int'(m_bpt) : 0;
        tot = depth[0] + depth[1] + depth[2] + depth[3];
        if ((q != PRIO_LEVELS - 1 && queued_bytes >= lim) || depth[q] >= LIFO_DEPTH ||
            tot >= TOTAL_CAP) begin
          throttled = 1'b1;
          note(EV_REFUSED, s.tag, s.prio, s.len, 1'b0);
        end else begin
          for (int k = depth[q]; k > 0; k--) lifo[q][k] = lifo[q][k-1];
          s.expiry = now_tick + m_exp;
          lifo[q][0] = s;
          depth[q]++;
          queued_bytes = queued_bytes + s.len;
          note(EV_QUEUED, s.tag, s.prio, s.len, 1'b0);
        end
      end
    end else begin
      now_tick++;
      budget = m_bpt;
      spent = 1'b0;
      for (int p = 0; p < PRIO_LEVELS; p++) begin
        i = 0;
        while (i < depth[p]) begin
          s = lifo[p][i];
          d = now_tick - s.expiry;
          if (d != 0 && !d[31]) begin
            release_bytes(s.len);
            drop_slot(p, i);
            note(EV_EXPIRED, s.tag, s.prio, s.len, 1'b0);
          end else begin
            i++;
          end
        end
      end
      for (int rnd = 0; rnd <= TOTAL_CAP; rnd++) begin
        served_n = 0;
        for (int p = PRIO_LEVELS - 1; p >= 0 && !spent; p--) begin
          i = 0;
          stop = 1'b0;
          while (i < depth[p] && !spent && !stop) begin
            s = lifo[p][i];
            dest = {s.key, s.port};
            hit = 1'b0;
            if (p == 0)
              for (int k = 0; k < served_n; k++) if (served[k] == dest) hit = 1'b1;
            if (hit) begin
              i++;
            end else begin
              r = try_send(s.port, s.ok, s.v6, s.len);
              if (r < 0) begin
                stop = 1'b1;
              end else begin
                if (r == EV_SENT_DIRECT && p == 0 && served_n < SEEN_DEPTH) begin
                  served[served_n] = dest;
                  served_n++;
                end
                release_bytes(s.len);
                drop_slot(p, i);
                note(r == EV_SENT_DIRECT ? EV_SENT_QUEUED : ultx_event_e'(r),
                     s.tag, s.prio, s.len, 1'b0);
              end
            end
          end
        end
        if (spent || queued_bytes == 0) break;
      end
      hit = !spent && throttled;
      if (hit) throttled = 1'b0;
      note(EV_TICK_DONE, '0, '0, '0, hit);
    end
    o = due_q.pop_back();
    o.last_of_run = 1'b1;
    due_q.push_back(o);
  endfunction

  // driver
  always @(negedge clk_i) begin
    logic go;
    go = 1'b0;
    if (start_i && !took) begin
      go = 1'b1;
    end else if (gap > 0) begin
      gap--;
    end else if (pkt_q.size() > 0 && rst_ni) begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 9) - 1;
      end else begin
        go = 1'b1;
        item_i <= pkt_q[0];
      end
    end
    start_i <= go;
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    ultx_out_t e;
    took = start_i && !busy_o && rst_ni;
    if (took) begin
      sched_predict(item_i);
      void'(pkt_q.pop_front());
    end
    if (res_valid_o) begin
      if (due_q.size() == 0) begin
        $error("unexpected beat: kind %0d tag %0h", res_o.event_kind, res_o.result_tag);
        errors++;
      end else begin
        e = due_q.pop_front();
        if (res_o.event_kind !== e.event_kind) begin
          $error("event_kind exp %0d got %0d", e.event_kind, res_o.event_kind); errors++;
        end
        if (res_o.result_tag !== e.result_tag) begin
          $error("result_tag exp %0h got %0h", e.result_tag, res_o.result_tag); errors++;
        end
        if (res_o.result_prio !== e.result_prio) begin
          $error("result_prio exp %0d got %0d", e.result_prio, res_o.result_prio); errors++;
        end
        if (res_o.result_length !== e.result_length) begin
          $error("result_length exp %0d got %0d", e.result_length, res_o.result_length);
          errors++;
        end
        if (res_o.buffered_now !== e.buffered_now) begin
          $error("buffered_now exp %0d got %0d", e.buffered_now, res_o.buffered_now);
          errors++;
        end
        if (res_o.wake_upper !== e.wake_upper) begin
          $error("wake_upper exp %0b got %0b", e.wake_upper, res_o.wake_upper); errors++;
        end
        if (res_o.last_of_run !== e.last_of_run) begin
          $error("last_of_run exp %0b got %0b", e.last_of_run, res_o.last_of_run); errors++;
        end
      end
    end
    if (took || res_valid_o) idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc >= WDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic ultx_in_t pkt(bit [1:0] pr, bit [31:0] key, bit [15:0] port, bit v6,
                                   bit [15:0] len, bit ok, bit [15:0] tag);
    ultx_in_t it;
    it.op = 1'b0; it.packet_prio = pr; it.dest_addr_key = key; it.dest_port = port;
    it.is_ipv6 = v6; it.packet_length = len; it.can_transmit = ok; it.packet_tag = tag;
    return it;
  endfunction

  function automatic ultx_in_t tick();
    ultx_in_t it;
    it = '0;
    it.packet_prio   = 2'($urandom());
    it.dest_addr_key = $urandom();
    it.dest_port     = 16'($urandom());
    it.is_ipv6       = 1'($urandom());
    it.packet_length = 16'($urandom());
    it.can_transmit  = 1'($urandom());
    it.packet_tag    = 16'($urandom());
    it.op = 1'b1;
    return it;
  endfunction

  function automatic ultx_in_t rand_item();
    bit [31:0] key;
    bit [15:0] port, len;
    if ($urandom_range(0, 5) == 0) return tick();
    key  = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 3);
    case ($urandom_range(0, 15))
      0:       port = '0;
      1, 2, 3: port = 16'($urandom());
      default: port = $urandom_range(0, 1) ? 16'd80 : 16'd443;
    endcase
    len = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2500));
    return pkt(2'($urandom()), key, port, 1'($urandom()), len,
               $urandom_range(0, 11) != 0, 16'($urandom()));
  endfunction

  task automatic write_reg(ultx_cfg_e idx, bit [19:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    case (idx)
      CFG_BYTES_PER_TICK: m_bpt = val;
      CFG_EXPIRE_TICKS:   m_exp = val[7:0];
      CFG_BACKLOG_FACTOR: m_fac = val[3:0];
      CFG_IPV4_PRESENT:   m_v4  = val[0];
      CFG_IPV6_PRESENT:   m_v6  = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic drain();
    while (pkt_q.size() > 0 || start_i || due_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic run_random(int n);
    for (int k = 0; k < n; k++) pkt_q.push_back(rand_item());
    drain();
  endtask

  initial begin
    m_bpt = 20'd65536; m_exp = 8'd5; m_fac = 4'd3; m_v4 = 1'b1; m_v6 = 1'b0;
    foreach (depth[p]) depth[p] = 0;
    queued_bytes = '0; now_tick = '0; budget = '0;
    spent = 1'b0; throttled = 1'b0; served_n = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);

    // directed: defaults, budget empty until the first tick
    pkt_q.push_back(pkt(2'd0, 32'd1, 16'd80, 1'b0, 16'd0, 1'b1, 16'h0001));
    pkt_q.push_back(pkt(2'd1, 32'd1, 16'd80, 1'b0, 16'd100, 1'b1, 16'h0002));
    pkt_q.push_back(pkt(2'd2, 32'd1, 16'd0, 1'b0, 16'd10, 1'b1, 16'h0003));
    pkt_q.push_back(tick());
    pkt_q.push_back(pkt(2'd3, '1, '1, 1'b0, '1, 1'b1, '1));
    pkt_q.push_back(pkt(2'd0, 32'd2, 16'd0, 1'b1, 16'd5, 1'b1, 16'h0004));
    pkt_q.push_back(pkt(2'd1, 32'd2, 16'd9, 1'b0, 16'd5, 1'b0, 16'h0005));
    pkt_q.push_back(pkt(2'd2, 32'd2, 16'd9, 1'b1, 16'd5, 1'b1, 16'h0006));
    pkt_q.push_back(pkt(2'd0, 32'd7, 16'd1, 1'b0, 16'd200, 1'b1, 16'h0007));
    pkt_q.push_back(pkt(2'd0, 32'd7, 16'd1, 1'b0, 16'd300, 1'b1, 16'h0008));
    pkt_q.push_back(pkt(2'd0, 32'd8, 16'd1, 1'b0, 16'd400, 1'b1, 16'h0009));
    pkt_q.push_back(pkt(2'd3, 32'd8, 16'd1, 1'b0, 16'd0, 1'b1, 16'h000a));
    for (int k = 0; k < 7; k++) pkt_q.push_back(tick());
    drain();

    // tight budget: queueing, refusals, seen-set skips, expiry
    write_reg(CFG_BYTES_PER_TICK, 20'd3000);
    write_reg(CFG_EXPIRE_TICKS, 20'hABC03);
    write_reg(CFG_BACKLOG_FACTOR, 20'd1);
    write_reg(CFG_IPV4_PRESENT, 20'd1);
    write_reg(CFG_IPV6_PRESENT, 20'hFFFFF);
    for (int k = 0; k < 12; k++)
      pkt_q.push_back(pkt(2'd0, 32'd3, 16'd80, 1'b0, 16'd50, 1'b1, 16'(16'h100 + k)));
    pkt_q.push_back(tick());
    run_random(45);
    run_random(45);

    // zero budget, immediate expiry, no flow-control headroom
    write_reg(CFG_BYTES_PER_TICK, 20'd0);
    write_reg(CFG_EXPIRE_TICKS, 20'd0);
    write_reg(CFG_BACKLOG_FACTOR, 20'd0);
    write_reg(CFG_IPV4_PRESENT, 20'd0);
    run_random(60);

    // largest settings
    write_reg(CFG_BYTES_PER_TICK, 20'hFFFFF);
    write_reg(CFG_EXPIRE_TICKS, 20'd255);
    write_reg(CFG_BACKLOG_FACTOR, 20'd15);
    write_reg(CFG_IPV4_PRESENT, 20'd1);
    write_reg(CFG_IPV6_PRESENT, 20'd1);
    run_random(80);

    // no socket at all
    write_reg(CFG_BYTES_PER_TICK, 20'd5000);
    write_reg(CFG_EXPIRE_TICKS, 20'd2);
    write_reg(CFG_BACKLOG_FACTOR, 20'd2);
    write_reg(CFG_IPV4_PRESENT, 20'd0);
    write_reg(CFG_IPV6_PRESENT, 20'd0);
    run_random(60);

    // back to mid settings, no gaps
    write_reg(CFG_BYTES_PER_TICK, 20'd20000);
    write_reg(CFG_EXPIRE_TICKS, 20'd8);
    write_reg(CFG_BACKLOG_FACTOR, 20'd4);
    write_reg(CFG_IPV4_PRESENT, 20'd1);
    write_reg(CFG_IPV6_PRESENT, 20'd1);
    calm = 1'b1;
    run_random(100);

    if (due_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
